FILE: hdl/assert_macros.svh
// Assertion helpers for the noise generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");
`define PN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");
`else
`define PN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/pn2d_pkg.sv
package pn2d_pkg;

    localparam int TABLE_SIZE     = 256;
    localparam int IDX_W          = 8;
    localparam int HASH_W         = 2;
    localparam int STEP_W         = 24;
    localparam int OUT_W          = 16;
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd256;

    // config register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 1'b1;

    // request kinds (tuser)
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // gradient selection, low two hash bits
    localparam logic [HASH_W-1:0] GRAD_PP = 2'd0;  //  x + y
    localparam logic [HASH_W-1:0] GRAD_NP = 2'd1;  // -x + y
    localparam logic [HASH_W-1:0] GRAD_PN = 2'd2;  //  x - y
    localparam logic [HASH_W-1:0] GRAD_NN = 2'd3;  // -x - y

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] val;
        logic [IDX_W-1:0] xi;
        logic [IDX_W-1:0] yi;
    } t_perm_req;

    typedef struct packed {
        logic [HASH_W-1:0] aa;
        logic [HASH_W-1:0] ab;
        logic [HASH_W-1:0] ba;
        logic [HASH_W-1:0] bb;
    } t_corner_hash;

endpackage

FILE: hdl/pn2d_fade.sv
// Quintic fade 6t^5 - 15t^4 + 10t^3, three register stages.
module pn2d_fade #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic [FRAC_BITS:0]   o_fade
);

    localparam int PW = FRAC_BITS + 5;
    localparam logic [PW-1:0]          C6     = PW'(6);
    localparam logic [PW-1:0]          C15    = PW'(15);
    localparam logic [PW-1:0]          C10ONE = PW'(10) << FRAC_BITS;
    localparam logic [FRAC_BITS+3:0]   FX_ONE = (FRAC_BITS+4)'(1) << FRAC_BITS;

    logic [FRAC_BITS-1:0]   r_t_a;
    logic [FRAC_BITS-1:0]   r_t2;
    logic [FRAC_BITS-1:0]   r_t3;
    logic [FRAC_BITS+3:0]   r_poly;
    logic [FRAC_BITS:0]     r_fade;

    logic [2*FRAC_BITS-1:0] w_sq;
    logic [2*FRAC_BITS-1:0] w_cube;
    logic [PW-1:0]          w_poly;
    logic [2*FRAC_BITS+3:0] w_prod;
    logic [FRAC_BITS+3:0]   w_f;

    assign w_sq   = i_t * i_t;
    assign w_cube = r_t2 * r_t_a;
    // 10 + 6t^2 added first so the running value never goes negative
    assign w_poly = ({5'b0, r_t2} * C6) + C10ONE - ({5'b0, r_t_a} * C15);
    assign w_prod = r_t3 * r_poly;
    assign w_f    = w_prod[2*FRAC_BITS+3:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t_a  <= i_t;
            r_t2   <= w_sq[2*FRAC_BITS-1:FRAC_BITS];
            r_t3   <= w_cube[2*FRAC_BITS-1:FRAC_BITS];
            r_poly <= w_poly[FRAC_BITS+3:0];
            r_fade <= (w_f > FX_ONE) ? FX_ONE[FRAC_BITS:0] : w_f[FRAC_BITS:0];
        end
    end

    assign o_fade = r_fade;

endmodule

FILE: hdl/pn2d_perm.sv
// Two-level permutation hash. Three copies of the table, each with
// one write and two registered reads, so a pixel enters every cycle that i_en is high.
// Loads write each copy at the stage that reads it, keeping order.
module pn2d_perm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  pn2d_pkg::t_perm_req     i_req,
    output pn2d_pkg::t_corner_hash  o_hash
);

    logic [pn2d_pkg::IDX_W-1:0]  r_mem_a [pn2d_pkg::TABLE_SIZE];
    logic [pn2d_pkg::HASH_W-1:0] r_mem_b [pn2d_pkg::TABLE_SIZE];
    logic [pn2d_pkg::HASH_W-1:0] r_mem_c [pn2d_pkg::TABLE_SIZE];

    logic [pn2d_pkg::IDX_W-1:0] r_pa0;
    logic [pn2d_pkg::IDX_W-1:0] r_pa1;
    logic [pn2d_pkg::IDX_W-1:0] r_yi2;
    logic                       r_load2;
    logic [pn2d_pkg::IDX_W-1:0] r_idx2;
    logic [pn2d_pkg::IDX_W-1:0] r_val2;
    pn2d_pkg::t_corner_hash     r_hash;

    logic [pn2d_pkg::IDX_W-1:0] w_xi1;
    logic [pn2d_pkg::IDX_W-1:0] w_a0;
    logic [pn2d_pkg::IDX_W-1:0] w_a0n;
    logic [pn2d_pkg::IDX_W-1:0] w_a1;
    logic [pn2d_pkg::IDX_W-1:0] w_a1n;

    assign w_xi1 = i_req.xi + 8'd1;
    assign w_a0  = r_pa0 + r_yi2;
    assign w_a0n = w_a0 + 8'd1;
    assign w_a1  = r_pa1 + r_yi2;
    assign w_a1n = w_a1 + 8'd1;

    // first level
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_req.load) begin
                r_mem_a[i_req.idx] <= i_req.val;
            end
            r_pa0  <= r_mem_a[i_req.xi];
            r_pa1  <= r_mem_a[w_xi1];
            r_yi2  <= i_req.yi;
            r_idx2 <= i_req.idx;
            r_val2 <= i_req.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load2 <= 1'b0;
        end else if (i_en) begin
            r_load2 <= i_req.load;
        end
    end

    // second level, only the gradient bits are kept
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_load2) begin
                r_mem_b[r_idx2] <= r_val2[pn2d_pkg::HASH_W-1:0];
                r_mem_c[r_idx2] <= r_val2[pn2d_pkg::HASH_W-1:0];
            end
            r_hash.aa <= r_mem_b[w_a0];
            r_hash.ab <= r_mem_b[w_a0n];
            r_hash.ba <= r_mem_c[w_a1];
            r_hash.bb <= r_mem_c[w_a1n];
        end
    end

    assign o_hash = r_hash;

endmodule

FILE: hdl/pn2d_mix.sv
// Corner gradients and the three lerps, five register stages.
module pn2d_mix #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  pn2d_pkg::t_corner_hash        i_hash,
    input  logic [FRAC_BITS-1:0]          i_xf,
    input  logic [FRAC_BITS-1:0]          i_yf,
    input  logic [FRAC_BITS:0]            i_u,
    input  logic [FRAC_BITS:0]            i_v,
    output logic signed [FRAC_BITS+2:0]   o_res
);

    localparam int G  = FRAC_BITS + 3;
    localparam int PW = 2 * FRAC_BITS + 6;
    localparam logic signed [G-1:0] FX_ONE = G'(1) << FRAC_BITS;

    function automatic logic signed [G-1:0] grad(
        input logic [pn2d_pkg::HASH_W-1:0] h,
        input logic signed [G-1:0]         x,
        input logic signed [G-1:0]         y
    );
        logic signed [G-1:0] g;
        unique case (h)
            pn2d_pkg::GRAD_PP: g = x + y;
            pn2d_pkg::GRAD_NP: g = y - x;
            pn2d_pkg::GRAD_PN: g = x - y;
            pn2d_pkg::GRAD_NN: g = -x - y;
        endcase
        return g;
    endfunction

    logic signed [G-1:0] w_x;
    logic signed [G-1:0] w_xm;
    logic signed [G-1:0] w_y;
    logic signed [G-1:0] w_ym;

    assign w_x  = $signed({3'b0, i_xf});
    assign w_y  = $signed({3'b0, i_yf});
    assign w_xm = w_x - FX_ONE;
    assign w_ym = w_y - FX_ONE;

    // stage 4: gradients
    logic signed [G-1:0] r_g_aa;
    logic signed [G-1:0] r_g_ab;
    logic signed [G-1:0] r_g_ba;
    logic signed [G-1:0] r_g_bb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_aa <= grad(i_hash.aa, w_x,  w_y);
            r_g_ba <= grad(i_hash.ba, w_xm, w_y);
            r_g_ab <= grad(i_hash.ab, w_x,  w_ym);
            r_g_bb <= grad(i_hash.bb, w_xm, w_ym);
        end
    end

    // stage 5: u * (b - a) for both rows
    logic signed [G:0]           w_d1;
    logic signed [G:0]           w_d2;
    logic signed [FRAC_BITS+1:0] w_u_s;
    logic signed [PW-1:0]        r_p1;
    logic signed [PW-1:0]        r_p2;
    logic signed [G-1:0]         r_g_aa5;
    logic signed [G-1:0]         r_g_ab5;
    logic [FRAC_BITS:0]          r_v5;

    assign w_d1  = {r_g_ba[G-1], r_g_ba} - {r_g_aa[G-1], r_g_aa};
    assign w_d2  = {r_g_bb[G-1], r_g_bb} - {r_g_ab[G-1], r_g_ab};
    assign w_u_s = $signed({1'b0, i_u});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= w_u_s * w_d1;
            r_p2    <= w_u_s * w_d2;
            r_g_aa5 <= r_g_aa;
            r_g_ab5 <= r_g_ab;
            r_v5    <= i_v;
        end
    end

    // stage 6: a + floor(product / ONE)
    logic signed [PW-1:0] w_s1;
    logic signed [PW-1:0] w_s2;
    logic signed [G-1:0]  r_l1;
    logic signed [G-1:0]  r_l2;
    logic [FRAC_BITS:0]   r_v6;

    assign w_s1 = r_p1 >>> FRAC_BITS;
    assign w_s2 = r_p2 >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l1 <= r_g_aa5 + $signed(w_s1[G-1:0]);
            r_l2 <= r_g_ab5 + $signed(w_s2[G-1:0]);
            r_v6 <= r_v5;
        end
    end

    // stage 7: v * (l2 - l1)
    logic signed [G:0]           w_d3;
    logic signed [FRAC_BITS+1:0] w_v_s;
    logic signed [PW-1:0]        r_p3;
    logic signed [G-1:0]         r_l1_7;

    assign w_d3  = {r_l2[G-1], r_l2} - {r_l1[G-1], r_l1};
    assign w_v_s = $signed({1'b0, r_v6});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3   <= w_v_s * w_d3;
            r_l1_7 <= r_l1;
        end
    end

    // stage 8: final lerp
    logic signed [PW-1:0] w_s3;
    logic signed [G-1:0]  r_res;

    assign w_s3 = r_p3 >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_l1_7 + $signed(w_s3[G-1:0]);
        end
    end

    assign o_res = r_res;

endmodule

FILE: hdl/perlin_noise_2d_generator.sv
// A pixel request passes nine register stages on its way to o_m_tvalid
// (the edge that accepts the request loads the first).
// Throughput: one request per cycle while the output is not held, pixel or load; a load gives no output.
// All stages advance together; a held output stalls the whole pipe.
// Reset (i_rst_n low at a clock edge) empties the pipe and sets both steps
// to 256; the permutation table keeps its contents and must be loaded.
`include "assert_macros.svh"

module perlin_noise_2d_generator #(
    parameter int COORD_BITS = pn2d_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] table_index, [15:8] table_value, then column, then row, zero pad
    input  logic [((2*pn2d_pkg::IDX_W + 2*COORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // [0] cmd: 0 load table entry, 1 pixel
    input  logic                               i_s_tuser,
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [15:0] noise_value
    output logic [pn2d_pkg::OUT_W-1:0]         o_m_tdata,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [pn2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pn2d_pkg::STEP_W-1:0]        i_cfg_data
);

    localparam int PX_W = COORD_BITS + pn2d_pkg::STEP_W;
    localparam int G    = FRAC_BITS + 3;
    localparam int QW   = FRAC_BITS + 18;
    localparam logic signed [G:0] FX_ONE = (G+1)'(1) << FRAC_BITS;
    localparam logic [QW-1:0]     Q_MAX  = QW'(16'hFFFF);

    // ---------------------------------------------------------------
    // Step registers
    // ---------------------------------------------------------------
    logic [pn2d_pkg::STEP_W-1:0] r_x_step;
    logic [pn2d_pkg::STEP_W-1:0] r_y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_step <= pn2d_pkg::STEP_RESET;
            r_y_step <= pn2d_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pn2d_pkg::REG_X_STEP: r_x_step <= i_cfg_data;
                pn2d_pkg::REG_Y_STEP: r_y_step <= i_cfg_data;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline advance: every stage moves whenever the output register
    // is free or being drained this cycle.
    // ---------------------------------------------------------------
    logic w_en;
    logic r_o_valid;

    assign w_en       = !r_o_valid || i_m_tready;
    assign o_s_tready = w_en;

    // request fields
    logic [pn2d_pkg::IDX_W-1:0] w_in_idx;
    logic [pn2d_pkg::IDX_W-1:0] w_in_val;
    logic [COORD_BITS-1:0]      w_in_col;
    logic [COORD_BITS-1:0]      w_in_row;

    assign w_in_idx = i_s_tdata[0 +: pn2d_pkg::IDX_W];
    assign w_in_val = i_s_tdata[pn2d_pkg::IDX_W +: pn2d_pkg::IDX_W];
    assign w_in_col = i_s_tdata[2*pn2d_pkg::IDX_W +: COORD_BITS];
    assign w_in_row = i_s_tdata[2*pn2d_pkg::IDX_W + COORD_BITS +: COORD_BITS];

    // ---------------------------------------------------------------
    // Valid tracking. Stages 1 and 2 carry loads and pixels (the table
    // copies are written there); from stage 3 on only pixels remain.
    // ---------------------------------------------------------------
    logic       r_v1;
    logic       r_p1;
    logic       r_v2;
    logic       r_p2;
    logic [5:0] r_pv;     // stages 3..8

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_p1      <= pn2d_pkg::CMD_LOAD;
            r_v2      <= 1'b0;
            r_p2      <= pn2d_pkg::CMD_LOAD;
            r_pv      <= '0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_v1      <= i_s_tvalid;
            r_p1      <= i_s_tuser;
            r_v2      <= r_v1;
            r_p2      <= r_p1;
            r_pv      <= {r_pv[4:0], r_v2 && (r_p2 == pn2d_pkg::CMD_PIXEL)};
            r_o_valid <= r_pv[5];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: grid position = coordinate * step; the table uses its low 8 integer bits (Q8.F)
    // ---------------------------------------------------------------
    logic [pn2d_pkg::IDX_W-1:0] r_idx1;
    logic [pn2d_pkg::IDX_W-1:0] r_val1;
    logic [PX_W-1:0]            r_px1;
    logic [PX_W-1:0]            r_py1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx1 <= w_in_idx;
            r_val1 <= w_in_val;
            r_px1  <= w_in_col * r_x_step;
            r_py1  <= w_in_row * r_y_step;
        end
    end

    // ---------------------------------------------------------------
    // Stages 2-3: table lookups and fade run side by side.
    // Fractions are delayed to line up with the hashes at stage 3.
    // ---------------------------------------------------------------
    pn2d_pkg::t_perm_req    w_req;
    pn2d_pkg::t_corner_hash w_hash;

    assign w_req.load = r_v1 && (r_p1 == pn2d_pkg::CMD_LOAD);
    assign w_req.idx  = r_idx1;
    assign w_req.val  = r_val1;
    assign w_req.xi   = r_px1[FRAC_BITS +: pn2d_pkg::IDX_W];
    assign w_req.yi   = r_py1[FRAC_BITS +: pn2d_pkg::IDX_W];

    pn2d_perm u_perm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_req),
        .o_hash  (w_hash)
    );

    logic [FRAC_BITS-1:0] w_xf1;
    logic [FRAC_BITS-1:0] w_yf1;
    logic [FRAC_BITS-1:0] r_xf2;
    logic [FRAC_BITS-1:0] r_yf2;
    logic [FRAC_BITS-1:0] r_xf3;
    logic [FRAC_BITS-1:0] r_yf3;

    assign w_xf1 = r_px1[FRAC_BITS-1:0];
    assign w_yf1 = r_py1[FRAC_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xf2 <= w_xf1;
            r_yf2 <= w_yf1;
            r_xf3 <= r_xf2;
            r_yf3 <= r_yf2;
        end
    end

    // fade weights land at stage 4
    logic [FRAC_BITS:0] w_u4;
    logic [FRAC_BITS:0] w_v4;

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_t    (w_xf1),
        .o_fade (w_u4)
    );

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_t    (w_yf1),
        .o_fade (w_v4)
    );

    // ---------------------------------------------------------------
    // Stages 4-8: gradients and bilinear blend
    // ---------------------------------------------------------------
    logic signed [G-1:0] w_res8;

    pn2d_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hash (w_hash),
        .i_xf   (r_xf3),
        .i_yf   (r_yf3),
        .i_u    (w_u4),
        .i_v    (w_v4),
        .o_res  (w_res8)
    );

    // ---------------------------------------------------------------
    // Stage 9: (res + 1) / 2, rescale to Q0.16, clamp to 0..65535
    // ---------------------------------------------------------------
    logic signed [G:0]    w_half;
    logic [FRAC_BITS+1:0] w_half_pos;
    logic [QW-1:0]        w_q;
    logic [pn2d_pkg::OUT_W-1:0] w_noise;
    logic [pn2d_pkg::OUT_W-1:0] r_o_data;

    assign w_half     = {w_res8[G-1], w_res8} + FX_ONE;
    assign w_half_pos = w_half[FRAC_BITS+1:0];
    assign w_q        = ({16'b0, w_half_pos >> 1} << 16) >> FRAC_BITS;

    always_comb begin
        priority if (w_half[G] || (w_half == '0)) begin
            w_noise = '0;
        end else if (w_q > Q_MAX) begin
            w_noise = Q_MAX[pn2d_pkg::OUT_W-1:0];
        end else begin
            w_noise = w_q[pn2d_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= w_noise;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    logic w_load2;

    assign w_load2 = r_v2 && (r_p2 == pn2d_pkg::CMD_LOAD);

    // a stall freezes the valid bits of stages 1 to 8
    `PN_ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, !w_en, $stable({r_pv, r_v1, r_v2}))
    // a pixel leaving the blend stages reaches the output register
    `PN_ASSERT_NEXT(a_pixel_reaches_out, i_clk, i_rst_n, w_en && r_pv[5], o_m_tvalid)
    // a load is dropped after the table writes and never yields a result
    `PN_ASSERT_NEXT(a_load_dropped, i_clk, i_rst_n, w_en && w_load2, !r_pv[0])

endmodule
